// ----- sv/rms_pkg.sv -----
package rms_pkg;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
   } req_type;

   typedef struct packed {
      logic        [23:0] rms_level;
      logic signed [11:0] level_tenths_dbfs;
      logic        [6:0]  bar_length;
      logic        [9:0]  block_count;
   } rsp_type;

   localparam int MUL_W    = 64;
   localparam int MPLIER_W = 32;

   typedef struct packed {
      logic                start;
      logic [MUL_W-1:0]    mcand;
      logic [MPLIER_W-1:0] mplier;
      logic [MUL_W-1:0]    init;
   } mul_req_type;

   typedef struct packed {
      logic             busy;
      logic [MUL_W-1:0] prod;
   } mul_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_WAIT,
      ST_DIV,
      ST_SQRT,
      ST_BAR_START,
      ST_BAR_WAIT,
      ST_NORM,
      ST_LOG_START,
      ST_LOG_WAIT,
      ST_DB_START,
      ST_DB_WAIT,
      ST_OUT
   } state_type;

   localparam int SUM_W      = 40;
   localparam int RAD_W      = 48;
   localparam int ROOT_W     = 24;
   localparam int SREM_W     = 26;
   localparam int FRAC_W     = 30;
   localparam int X_W        = 32;
   localparam int STEP_W     = 6;
   localparam int DIV_STEPS  = 40;
   localparam int SQRT_STEPS = 24;
   localparam int LOG_STEPS  = 30;

   localparam logic [25:0]        DB_COEF      = 26'd63130566;
   localparam logic [MUL_W-1:0]   DB_ROUND     = 64'd1 << 49;
   localparam logic signed [11:0] SILENT_LEVEL = -12'sd1800;

endpackage

// ----- sv/block_rms_dbfs_meter.sv -----
// Block RMS meter: sums sample squares until a beat marked last or MAX_BLOCK
// beats, then returns RMS (Q16.8), level in tenths of dBFS, bar length and
// count. Everything runs through one shift-add multiplier (one multiplier bit
// per cycle) plus bit-serial divide and square-root loops. Each sample beat
// is squared serially before the next beat is taken. Block end runs the
// divide, the square root, the bar multiply, normalization, 30 log squarings
// and the dB multiply; no sample is taken meanwhile. A finished result waits
// in the output register while the next block's samples are accepted.
module block_rms_dbfs_meter #(
   parameter int MAX_BLOCK = 512,
   parameter int BAR_WIDTH = 80
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rms_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rms_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);

   rms_pkg::state_type state_ff, state_in;

   logic [rms_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       last_ff, last_in;
   logic [rms_pkg::SUM_W-1:0]  num_ff, num_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [rms_pkg::RAD_W-1:0]  rad_ff, rad_in;
   logic [rms_pkg::SREM_W-1:0] srem_ff, srem_in;
   logic [rms_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [rms_pkg::X_W-1:0]    x_ff, x_in;
   logic [4:0]                 z_ff, z_in;
   logic [rms_pkg::FRAC_W-1:0] frac_ff, frac_in;
   logic [rms_pkg::STEP_W-1:0] step_ff, step_in;
   logic [6:0]                 bar_ff, bar_in;
   logic signed [11:0]         lvl_ff, lvl_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rms_pkg::rsp_type           rsp_ff, rsp_in;

   rms_pkg::mul_req_type mul_req;
   rms_pkg::mul_sts_type mul_sts;

   logic [15:0]                  mag;
   logic [rms_pkg::SUM_W:0]      sum_ext;
   logic [CNT_W-1:0]             cnt_plus;
   logic [CNT_W:0]               div_trial;
   logic [rms_pkg::SREM_W+1:0]   sq_trial_rem;
   logic [rms_pkg::SREM_W+1:0]   sq_trial;
   logic [rms_pkg::X_W-1:0]      x_sq;
   logic [34:0]                  d_val;
   logic [7:0]                   bar_raw;
   logic [10:0]                  db_mag;

   rms_ser_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_sts (mul_sts)
   );

   assign mag          = req_data.sample[15] ? (~req_data.sample + 16'd1) : req_data.sample;
   assign sum_ext      = {1'b0, sum_ff} + {9'd0, mul_sts.prod[31:0]};
   assign cnt_plus     = cnt_ff + 1'b1;
   assign div_trial    = {rem_ff, num_ff[rms_pkg::SUM_W-1]};
   assign sq_trial_rem = {srem_ff, rad_ff[rms_pkg::RAD_W-1 -: 2]};
   assign sq_trial     = {2'b00, root_ff, 2'b01};
   assign x_sq         = mul_sts.prod[61:30];
   assign d_val        = {z_ff, 30'd0} - {5'd0, frac_ff};
   assign bar_raw      = mul_sts.prod[30:23];
   assign db_mag       = mul_sts.prod[60:50];

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      rad_in       = rad_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      x_in         = x_ff;
      z_in         = z_ff;
      frac_in      = frac_ff;
      step_in      = step_ff;
      bar_in       = bar_ff;
      lvl_in       = lvl_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      mul_req      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         rms_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               last_in        = req_data.last;
               mul_req.start  = 1'b1;
               mul_req.mcand  = 64'(mag);
               mul_req.mplier = 32'(mag);
               state_in       = rms_pkg::ST_SQ_WAIT;
            end
         end
         rms_pkg::ST_SQ_WAIT: begin
            if (!mul_sts.busy) begin
               sum_in = sum_ext[rms_pkg::SUM_W] ? '1 : sum_ext[rms_pkg::SUM_W-1:0];
               cnt_in = cnt_plus;
               if (last_ff || (cnt_plus >= CNT_W'(MAX_BLOCK))) begin
                  num_in   = sum_in;
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = rms_pkg::ST_DIV;
               end else begin
                  state_in = rms_pkg::ST_IDLE;
               end
            end
         end
         rms_pkg::ST_DIV: begin
            if (div_trial >= {1'b0, cnt_ff}) begin
               rem_in = CNT_W'(div_trial - {1'b0, cnt_ff});
               num_in = {num_ff[rms_pkg::SUM_W-2:0], 1'b1};
            end else begin
               rem_in = div_trial[CNT_W-1:0];
               num_in = {num_ff[rms_pkg::SUM_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == rms_pkg::STEP_W'(rms_pkg::DIV_STEPS - 1)) begin
               rad_in   = {num_in[31:0], 16'd0};
               srem_in  = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = rms_pkg::ST_SQRT;
            end
         end
         rms_pkg::ST_SQRT: begin
            if (sq_trial_rem >= sq_trial) begin
               srem_in = rms_pkg::SREM_W'(sq_trial_rem - sq_trial);
               root_in = {root_ff[rms_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = sq_trial_rem[rms_pkg::SREM_W-1:0];
               root_in = {root_ff[rms_pkg::ROOT_W-2:0], 1'b0};
            end
            rad_in  = {rad_ff[rms_pkg::RAD_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == rms_pkg::STEP_W'(rms_pkg::SQRT_STEPS - 1)) begin
               state_in = rms_pkg::ST_BAR_START;
            end
         end
         rms_pkg::ST_BAR_START: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = 64'(root_ff);
            mul_req.mplier = 32'(BAR_WIDTH);
            state_in       = rms_pkg::ST_BAR_WAIT;
         end
         rms_pkg::ST_BAR_WAIT: begin
            if (!mul_sts.busy) begin
               bar_in = (bar_raw > 8'(BAR_WIDTH)) ? 7'(BAR_WIDTH) : bar_raw[6:0];
               if (root_ff == '0) begin
                  lvl_in   = rms_pkg::SILENT_LEVEL;
                  state_in = rms_pkg::ST_OUT;
               end else begin
                  x_in     = {1'b0, root_ff, 7'd0};
                  z_in     = '0;
                  frac_in  = '0;
                  step_in  = '0;
                  state_in = rms_pkg::ST_NORM;
               end
            end
         end
         rms_pkg::ST_NORM: begin
            if (x_ff[30]) begin
               state_in = rms_pkg::ST_LOG_START;
            end else begin
               x_in = {x_ff[rms_pkg::X_W-2:0], 1'b0};
               z_in = z_ff + 5'd1;
            end
         end
         rms_pkg::ST_LOG_START: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = 64'(x_ff);
            mul_req.mplier = x_ff;
            state_in       = rms_pkg::ST_LOG_WAIT;
         end
         rms_pkg::ST_LOG_WAIT: begin
            if (!mul_sts.busy) begin
               frac_in = {frac_ff[rms_pkg::FRAC_W-2:0], x_sq[31]};
               x_in    = x_sq[31] ? {1'b0, x_sq[31:1]} : x_sq;
               step_in = step_ff + 1'b1;
               if (step_ff == rms_pkg::STEP_W'(rms_pkg::LOG_STEPS - 1)) begin
                  state_in = rms_pkg::ST_DB_START;
               end else begin
                  state_in = rms_pkg::ST_LOG_START;
               end
            end
         end
         rms_pkg::ST_DB_START: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = 64'(d_val);
            mul_req.mplier = 32'(rms_pkg::DB_COEF);
            mul_req.init   = rms_pkg::DB_ROUND;
            state_in       = rms_pkg::ST_DB_WAIT;
         end
         rms_pkg::ST_DB_WAIT: begin
            if (!mul_sts.busy) begin
               lvl_in   = -$signed({1'b0, db_mag});
               state_in = rms_pkg::ST_OUT;
            end
         end
         rms_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_in.rms_level         = root_ff;
               rsp_in.level_tenths_dbfs = lvl_ff;
               rsp_in.bar_length        = bar_ff;
               rsp_in.block_count       = 10'(cnt_ff);
               sum_in                   = '0;
               cnt_in                   = '0;
               state_in                 = rms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rms_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rms_pkg::ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      x_ff    <= x_in;
      z_ff    <= z_in;
      frac_ff <= frac_in;
      step_ff <= step_in;
      bar_ff  <= bar_in;
      lvl_ff  <= lvl_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_open_block_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rms_pkg::ST_IDLE) |-> (32'(cnt_ff) < 32'(MAX_BLOCK)))
      else $error("open block count reached MAX_BLOCK");

   a_accept_starts_square: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == rms_pkg::ST_SQ_WAIT) && mul_sts.busy)
      else $error("accepted beat did not start squaring");

   a_mul_free_on_start: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !mul_sts.busy)
      else $error("multiplier started while busy");

   a_silent_level: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         ((rsp_ff.rms_level == '0) == (rsp_ff.level_tenths_dbfs == rms_pkg::SILENT_LEVEL)))
      else $error("silent level mismatch");

endmodule

// ----- sv/rms_ser_mul.sv -----
module rms_ser_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  rms_pkg::mul_req_type mul_req,
   output rms_pkg::mul_sts_type mul_sts
);

   logic                         busy_ff, busy_in;
   logic [rms_pkg::MUL_W-1:0]    mcand_ff, mcand_in;
   logic [rms_pkg::MPLIER_W-1:0] mplier_ff, mplier_in;
   logic [rms_pkg::MUL_W-1:0]    acc_ff, acc_in;

   always_comb begin
      busy_in   = busy_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (mul_req.start) begin
         busy_in   = 1'b1;
         mcand_in  = mul_req.mcand;
         mplier_in = mul_req.mplier;
         acc_in    = mul_req.init;
      end else if (busy_ff) begin
         if (mplier_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[rms_pkg::MUL_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[rms_pkg::MPLIER_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign mul_sts.busy = busy_ff;
   assign mul_sts.prod = acc_ff;

endmodule

// ----- verif/rms_meter_checker.sv -----
module rms_meter_checker #(
   parameter int MAX_BLOCK = 512,
   parameter int BAR_WIDTH = 80
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  rms_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rms_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0]        SQ_SUM_MAX    = 64'hFF_FFFF_FFFF;
   localparam logic [63:0]        LOG_COEF_Q20  = 64'd63130566;
   localparam logic [63:0]        LOG_HALF      = 64'd1 << 49;
   localparam logic signed [11:0] SILENT_TENTHS = -12'sd1800;

   rms_pkg::rsp_type readings_due[$];
   rms_pkg::rsp_type want;
   logic [63:0]      sq_sum;
   int unsigned      in_block;
   int               s_ext;

   function automatic logic [63:0] root_floor64(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] probe;
      res   = '0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v   = v - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [11:0] tenths_of_dbfs(logic [31:0] r);
      int unsigned e;
      logic [63:0] x;
      logic [63:0] frac;
      logic [63:0] d;
      logic [63:0] mag;
      logic [63:0] neg;
      if (r == 0) return SILENT_TENTHS;
      e = 0;
      while (e < 31 && (r >> (e + 1)) != 0) e++;
      if (e > 23) e = 23;
      // normalized mantissa, Q1.30
      x    = ({32'd0, r} << 30) >> e;
      frac = '0;
      for (int i = 0; i < 30; i++) begin
         x    = (x * x) >> 30;
         frac = frac << 1;
         if (x >= (64'd2 << 30)) begin
            frac = frac | 64'd1;
            x    = x >> 1;
         end
      end
      d   = (64'(23 - e) << 30) - frac;
      mag = (d * LOG_COEF_Q20 + LOG_HALF) >> 50;
      neg = 64'd0 - mag;
      return neg[11:0];
   endfunction

   function automatic rms_pkg::rsp_type close_block(logic [63:0] sum, int unsigned n);
      rms_pkg::rsp_type o;
      logic [63:0]      root;
      logic [63:0]      bar;
      root = root_floor64((sum / 64'(n)) << 16);
      bar  = (root * 64'(BAR_WIDTH)) >> 23;
      if (bar > 64'(BAR_WIDTH)) bar = 64'(BAR_WIDTH);
      o.rms_level         = root[23:0];
      o.level_tenths_dbfs = tenths_of_dbfs(root[31:0]);
      o.bar_length        = bar[6:0];
      o.block_count       = n[9:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint wanted);
      $display("%0t ns mismatch %s: got %0d want %0d", $time, what, got, wanted);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sq_sum   = '0;
         in_block = 0;
         readings_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               report_mismatch("result beat with none due, count", rsp_data.block_count, 0);
            end else begin
               want = readings_due.pop_front();
               if (rsp_data.rms_level !== want.rms_level)
                  report_mismatch("rms_level", rsp_data.rms_level, want.rms_level);
               if (rsp_data.level_tenths_dbfs !== want.level_tenths_dbfs)
                  report_mismatch("level_tenths_dbfs", $signed(rsp_data.level_tenths_dbfs),
                                  $signed(want.level_tenths_dbfs));
               if (rsp_data.bar_length !== want.bar_length)
                  report_mismatch("bar_length", rsp_data.bar_length, want.bar_length);
               if (rsp_data.block_count !== want.block_count)
                  report_mismatch("block_count", rsp_data.block_count, want.block_count);
            end
         end
         if (req_valid && req_ready) begin
            s_ext  = $signed(req_data.sample);
            sq_sum = sq_sum + 64'(s_ext * s_ext);
            if (sq_sum > SQ_SUM_MAX) sq_sum = SQ_SUM_MAX;
            in_block++;
            if (req_data.last || in_block >= MAX_BLOCK) begin
               readings_due.push_back(close_block(sq_sum, in_block));
               sq_sum   = '0;
               in_block = 0;
            end
         end
      end
      pending = readings_due.size();
   end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BLOCK = 512;
   localparam int BAR_WIDTH = 80;
   localparam int HOLD_LEN  = 6000;

   typedef enum int {
      KIND_ZERO,
      KIND_SMALL,
      KIND_FULL,
      KIND_EXTREME
   } amp_kind_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   rms_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rms_pkg::rsp_type rsp_data;

   int fails;
   int pending;
   int idle_pct   = 0;
   int stall_pct  = 0;
   int hold_token = 0;
   int hold_seen  = 0;
   int hold_left  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   block_rms_dbfs_meter #(
      .MAX_BLOCK(MAX_BLOCK),
      .BAR_WIDTH(BAR_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rms_meter_checker #(
      .MAX_BLOCK(MAX_BLOCK),
      .BAR_WIDTH(BAR_WIDTH)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fails),
      .pending    (pending)
   );

   // result side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   task automatic send_beat(logic [15:0] s, logic l);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample: s, last: l};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_sample(amp_kind_type kind);
      int k;
      int v;
      case (kind)
         KIND_ZERO: return 16'h0000;
         KIND_SMALL: begin
            k = $urandom_range(15, 0);
            v = $urandom_range((1 << k) - 1, 0);
            return ($urandom_range(1, 0) != 0) ? 16'(-v) : 16'(v);
         end
         KIND_FULL: return 16'($urandom);
         default: begin
            case ($urandom_range(2, 0))
               0:       return 16'h8000;
               1:       return 16'h7FFF;
               default: return 16'h8001;
            endcase
         end
      endcase
   endfunction

   task automatic send_block(int len, amp_kind_type kind, bit noisy);
      for (int i = 0; i < len; i++) begin
         if (i == len - 1)
            send_beat(pick_sample(kind), 1'b1);
         else if (noisy)
            send_beat(pick_sample(kind), ($urandom_range(3, 0) == 0));
         else
            send_beat(pick_sample(kind), 1'b0);
      end
   endtask

   task automatic run_random(int beats);
      int           sent;
      int           r;
      int           len;
      int           w;
      amp_kind_type kind;
      sent = 0;
      while (sent < beats) begin
         r   = $urandom_range(99, 0);
         len = (r < 85) ? $urandom_range(12, 1) :
               (r < 97) ? $urandom_range(64, 13) : $urandom_range(200, 65);
         w   = $urandom_range(99, 0);
         kind = (w < 10) ? KIND_ZERO : (w < 50) ? KIND_SMALL :
                (w < 90) ? KIND_FULL : KIND_EXTREME;
         send_block(len, kind, ($urandom_range(19, 0) == 0));
         sent += len;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_beat(16'h0000, 1'b1);    // silent block
      send_beat(16'h8000, 1'b1);    // full scale
      send_beat(16'h7FFF, 1'b1);
      send_beat(16'h8001, 1'b1);
      send_beat(16'h0001, 1'b1);
      send_beat(16'hFFFF, 1'b1);
      send_beat(16'h0000, 1'b0);    // mean floors to zero
      send_beat(16'h0000, 1'b0);
      send_beat(16'h0001, 1'b1);
      send_beat(16'd100, 1'b0);
      send_beat(16'hFF38, 1'b0);
      send_beat(16'd300, 1'b1);
      send_beat(16'h5555, 1'b0);
      send_beat(16'hAAAA, 1'b1);
      send_beat(16'h0101, 1'b0);
      send_beat(16'hFEFE, 1'b1);
      send_beat(16'h4000, 1'b1);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 50; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 50; end
            default: begin idle_pct = 13; stall_pct = 13; end
         endcase
         if (p == 0) hold_token++;
         run_random(40);
         if (p == 3) begin
            // full-scale beats closed by the size limit, then a short
            // tail that ends on last
            for (int i = 0; i < MAX_BLOCK; i++) send_beat(16'h8000, 1'b0);
            for (int i = 0; i < 39; i++) send_beat(16'($urandom), 1'b0);
            send_beat(16'($urandom), 1'b1);
         end
         wait_drained();
      end

      stall_pct = 0;
      repeat (1500) @(negedge clock);
      if (fails == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- block_rms_dbfs_meter.f -----
sv/rms_pkg.sv
sv/rms_ser_mul.sv
sv/block_rms_dbfs_meter.sv
verif/rms_meter_checker.sv
verif/tb_top.sv
